[sv/lfps_pkg.sv]
// lfps_pkg: shared types, register codes and constants of the line follower steering block
// no dependencies
`timescale 1ns / 1ps

package lfps_pkg;

   localparam int INTEGRAL_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int GAIN_WIDTH  = 16;
   localparam int SPEED_WIDTH = 9;
   localparam int ERROR_WIDTH = 3;
   localparam int DIFF_WIDTH  = 4;
   localparam int SENSOR_WIDTH = 6;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [GAIN_WIDTH-1:0]         PROP_GAIN_RESET  = 16'd3840;
   localparam logic [GAIN_WIDTH-1:0]         INTEG_GAIN_RESET = 16'd32;
   localparam logic [GAIN_WIDTH-1:0]         DERIV_GAIN_RESET = 16'd5120;
   localparam logic signed [SPEED_WIDTH-1:0] BASE_SPEED_RESET = 9'sd100;

   // register indexes on the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PROP_GAIN  = 8'd0,
      REG_INTEG_GAIN = 8'd1,
      REG_DERIV_GAIN = 8'd2,
      REG_BASE_SPEED = 8'd3
   } reg_index_type;

   // gains and base speed handed to the back end
   typedef struct packed {
      logic [GAIN_WIDTH-1:0]         prop_gain;
      logic [GAIN_WIDTH-1:0]         integ_gain;
      logic [GAIN_WIDTH-1:0]         deriv_gain;
      logic signed [SPEED_WIDTH-1:0] base_speed;
   } cfg_type;

   // line error codes
   localparam logic signed [ERROR_WIDTH-1:0] ERR_POS3 = 3'sd3;
   localparam logic signed [ERROR_WIDTH-1:0] ERR_POS2 = 3'sd2;
   localparam logic signed [ERROR_WIDTH-1:0] ERR_POS1 = 3'sd1;
   localparam logic signed [ERROR_WIDTH-1:0] ERR_NEG1 = -3'sd1;
   localparam logic signed [ERROR_WIDTH-1:0] ERR_NEG2 = -3'sd2;
   localparam logic signed [ERROR_WIDTH-1:0] ERR_NEG3 = -3'sd3;

   localparam int SPEED_LIMIT = 255;

endpackage

[sv/lfps_front.sv]
// lfps_front: classifies a sensor sample into a line error and updates the pid state
// depends on lfps_pkg
`timescale 1ns / 1ps

module lfps_front #(
   parameter int INTEGRAL_WIDTH = lfps_pkg::INTEGRAL_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [lfps_pkg::SENSOR_WIDTH-1:0]          sensor_bits,
   output logic                                       push_valid,
   input  logic                                       push_ready,
   output logic signed [lfps_pkg::ERROR_WIDTH-1:0]    push_error,
   output logic signed [lfps_pkg::DIFF_WIDTH-1:0]     push_diff,
   output logic signed [INTEGRAL_WIDTH-1:0]           push_integral
);
   import lfps_pkg::*;

   logic signed [ERROR_WIDTH-1:0]    prev_error_ff, prev_error_in;
   logic signed [INTEGRAL_WIDTH-1:0] integral_ff, integral_in;
   logic signed [ERROR_WIDTH-1:0]    error_now;
   logic signed [INTEGRAL_WIDTH:0]   integral_sum;
   logic                             accept;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign accept     = in_valid && push_ready;

   // highest of the upper three sensors wins, then lowest of the lower three
   always_comb begin
      if (sensor_bits[5]) begin
         error_now = ERR_POS3;
      end else if (sensor_bits[4]) begin
         error_now = ERR_POS2;
      end else if (sensor_bits[3]) begin
         error_now = ERR_POS1;
      end else if (sensor_bits[0]) begin
         error_now = ERR_NEG3;
      end else if (sensor_bits[1]) begin
         error_now = ERR_NEG2;
      end else if (sensor_bits[2]) begin
         error_now = ERR_NEG1;
      end else begin
         error_now = prev_error_ff;
      end
   end

   // saturating integral, overflow when the two top bits differ
   always_comb begin
      integral_sum = {integral_ff[INTEGRAL_WIDTH-1], integral_ff}
                   + {{(INTEGRAL_WIDTH-2){error_now[ERROR_WIDTH-1]}}, error_now};
      if (integral_sum[INTEGRAL_WIDTH] != integral_sum[INTEGRAL_WIDTH-1]) begin
         integral_in = integral_sum[INTEGRAL_WIDTH] ?
                       {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}} :
                       {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
      end else begin
         integral_in = integral_sum[INTEGRAL_WIDTH-1:0];
      end
   end

   assign prev_error_in = error_now;
   assign push_error    = error_now;
   assign push_diff     = {error_now[ERROR_WIDTH-1], error_now}
                        - {prev_error_ff[ERROR_WIDTH-1], prev_error_ff};
   assign push_integral = integral_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else if (accept) begin
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
      end
   end

endmodule

[sv/lfps_queue.sv]
// lfps_queue: short fifo between front and back ends
// depends on lfps_pkg
`timescale 1ns / 1ps

module lfps_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   import lfps_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[sv/lfps_back.sv]
// lfps_back: pid products, truncation and speed saturation, with output register
// depends on lfps_pkg
`timescale 1ns / 1ps

module lfps_back #(
   parameter int INTEGRAL_WIDTH = lfps_pkg::INTEGRAL_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  lfps_pkg::cfg_type                         cfg,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic signed [lfps_pkg::ERROR_WIDTH-1:0]   in_error,
   input  logic signed [lfps_pkg::DIFF_WIDTH-1:0]    in_diff,
   input  logic signed [INTEGRAL_WIDTH-1:0]          in_integral,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic signed [lfps_pkg::ERROR_WIDTH-1:0]   out_error,
   output logic signed [lfps_pkg::SPEED_WIDTH-1:0]   out_left,
   output logic signed [lfps_pkg::SPEED_WIDTH-1:0]   out_right
);
   import lfps_pkg::*;

   localparam int PP_W  = GAIN_WIDTH + 1 + ERROR_WIDTH;
   localparam int IP_W  = GAIN_WIDTH + 1 + INTEGRAL_WIDTH;
   localparam int DP_W  = GAIN_WIDTH + 1 + DIFF_WIDTH;
   localparam int ACC_W = IP_W + 2;
   localparam int CW    = ACC_W - 8;
   localparam int SW    = CW + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'(SPEED_LIMIT);
   localparam logic signed [SW-1:0] SAT_LO = -SW'(SPEED_LIMIT);
   localparam logic signed [ACC_W-1:0] ROUND_ADJ = ACC_W'(255);

   // stage 1: the three products
   logic                          s1_v_ff, s1_ready;
   logic signed [PP_W-1:0]        prod_p_ff, prod_p_in;
   logic signed [IP_W-1:0]        prod_i_ff, prod_i_in;
   logic signed [DP_W-1:0]        prod_d_ff, prod_d_in;
   logic signed [ERROR_WIDTH-1:0] s1_error_ff;
   logic signed [GAIN_WIDTH:0]    pg_s, ig_s, dg_s;

   // stage 2: correction truncated toward zero
   logic                          s2_v_ff, s2_ready;
   logic signed [ACC_W-1:0]       acc, acc_adj;
   logic signed [CW-1:0]          corr_ff, corr_in;
   logic signed [ERROR_WIDTH-1:0] s2_error_ff;

   // output register
   logic                          out_v_ff, o_ready;
   logic signed [SW-1:0]          sum_l, sum_r;
   logic signed [SPEED_WIDTH-1:0] left_ff, left_in, right_ff, right_in;
   logic signed [ERROR_WIDTH-1:0] out_error_ff;

   assign o_ready  = !out_v_ff || out_ready;
   assign s2_ready = !s2_v_ff || o_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;

   assign pg_s = {1'b0, cfg.prop_gain};
   assign ig_s = {1'b0, cfg.integ_gain};
   assign dg_s = {1'b0, cfg.deriv_gain};

   assign prod_p_in = pg_s * in_error;
   assign prod_i_in = ig_s * in_integral;
   assign prod_d_in = dg_s * in_diff;

   always_comb begin
      acc     = ACC_W'(prod_p_ff) + ACC_W'(prod_i_ff) + ACC_W'(prod_d_ff);
      acc_adj = acc[ACC_W-1] ? acc + ROUND_ADJ : acc;
      corr_in = acc_adj[ACC_W-1:8];
   end

   always_comb begin
      sum_l = SW'(cfg.base_speed) + SW'(corr_ff);
      sum_r = SW'(cfg.base_speed) - SW'(corr_ff);
      if (sum_l > SAT_HI) begin
         left_in = SPEED_WIDTH'(SPEED_LIMIT);
      end else if (sum_l < SAT_LO) begin
         left_in = -SPEED_WIDTH'(SPEED_LIMIT);
      end else begin
         left_in = sum_l[SPEED_WIDTH-1:0];
      end
      if (sum_r > SAT_HI) begin
         right_in = SPEED_WIDTH'(SPEED_LIMIT);
      end else if (sum_r < SAT_LO) begin
         right_in = -SPEED_WIDTH'(SPEED_LIMIT);
      end else begin
         right_in = sum_r[SPEED_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (o_ready) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         prod_p_ff   <= prod_p_in;
         prod_i_ff   <= prod_i_in;
         prod_d_ff   <= prod_d_in;
         s1_error_ff <= in_error;
      end
      if (s2_ready) begin
         corr_ff     <= corr_in;
         s2_error_ff <= s1_error_ff;
      end
      if (o_ready) begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         out_error_ff <= s2_error_ff;
      end
   end

   assign out_valid = out_v_ff;
   assign out_error = out_error_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;

endmodule

[sv/line_follow_pid_steering.sv]
// line_follow_pid_steering: samples reach rsp_ through the queue, product, correction and
// output registers; one sample per cycle unless rsp_tready stalls: the front end updates
// error and integral state in the accept cycle, the back end runs products, truncation
// and saturation as three stages; synchronous active-high reset clears pid state, queue
// and pipeline valids, and loads the default gains (15, 0.125, 20) and base speed 100
`timescale 1ns / 1ps

module line_follow_pid_steering #(
   parameter int INTEGRAL_WIDTH = lfps_pkg::INTEGRAL_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sensor sample stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,   // [5:0] sensor_bits
   // steering result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [23:0]                            rsp_tdata,   // [2:0] line_error,
                                                               // [11:3] left_speed,
                                                               // [20:12] right_speed
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lfps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lfps_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import lfps_pkg::*;

   localparam int Q_W = ERROR_WIDTH + DIFF_WIDTH + INTEGRAL_WIDTH;

   cfg_type cfg_ff, cfg_in;

   logic                          push_valid, push_ready;
   logic signed [ERROR_WIDTH-1:0] push_error;
   logic signed [DIFF_WIDTH-1:0]  push_diff;
   logic signed [INTEGRAL_WIDTH-1:0] push_integral;
   logic [Q_W-1:0]                q_wr_data, q_rd_data;
   logic                          q_rd_valid, q_rd_ready;

   logic signed [ERROR_WIDTH-1:0] out_error;
   logic signed [SPEED_WIDTH-1:0] out_left, out_right;

   // register writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_PROP_GAIN:  cfg_in.prop_gain  = csr_data;
            REG_INTEG_GAIN: cfg_in.integ_gain = csr_data;
            REG_DERIV_GAIN: cfg_in.deriv_gain = csr_data;
            REG_BASE_SPEED: cfg_in.base_speed = csr_data[SPEED_WIDTH-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= PROP_GAIN_RESET;
         cfg_ff.integ_gain <= INTEG_GAIN_RESET;
         cfg_ff.deriv_gain <= DERIV_GAIN_RESET;
         cfg_ff.base_speed <= BASE_SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: error classification and pid state
   lfps_front #(
      .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .sensor_bits  (req_tdata[SENSOR_WIDTH-1:0]),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_error   (push_error),
      .push_diff    (push_diff),
      .push_integral(push_integral)
   );

   // queue entry: error, difference and updated integral
   assign q_wr_data = {push_integral, push_diff, push_error};

   lfps_queue #(
      .WIDTH(Q_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_valid(push_valid),
      .wr_ready(push_ready),
      .wr_data (q_wr_data),
      .rd_valid(q_rd_valid),
      .rd_ready(q_rd_ready),
      .rd_data (q_rd_data)
   );

   // back end: weighted sum, truncation toward zero and motor speeds
   lfps_back #(
      .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (q_rd_valid),
      .in_ready   (q_rd_ready),
      .in_error   (q_rd_data[ERROR_WIDTH-1:0]),
      .in_diff    (q_rd_data[ERROR_WIDTH +: DIFF_WIDTH]),
      .in_integral(q_rd_data[ERROR_WIDTH + DIFF_WIDTH +: INTEGRAL_WIDTH]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_error  (out_error),
      .out_left   (out_left),
      .out_right  (out_right)
   );

   // pack result fields from the lowest bit up, zero filled to whole bytes
   assign rsp_tdata = {3'b000, out_right, out_left, out_error};

endmodule

[verif/tb_line_follow_pid_steering.sv]
// tb_line_follow_pid_steering: self-checking bench for the line follower pid steering block
// drives sensor samples and register writes, predicts every result and checks it in order
// depends on lfps_pkg and line_follow_pid_steering
`timescale 1ns / 1ps

module tb_line_follow_pid_steering;
   import lfps_pkg::*;

   localparam int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEFAULT;
   localparam int REG_COUNT      = 4;     // first index past the register list
   localparam int MAX_REPORTS    = 10;

   // one steering result as it leaves the block
   typedef struct packed {
      logic signed [ERROR_WIDTH-1:0] line_error;
      logic signed [SPEED_WIDTH-1:0] left_speed;
      logic signed [SPEED_WIDTH-1:0] right_speed;
   } steer_result_type;

   // clock, reset and every block input start at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [7:0]                  req_tdata  = '0;   // [5:0] sensor_bits
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [23:0]                 rsp_tdata;         // [2:0] line_error, [11:3] left_speed,
                                                   // [20:12] right_speed
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data   = '0;

   // steering model state: gains, base speed, held error and integral
   logic [GAIN_WIDTH-1:0]             kp_gain;
   logic [GAIN_WIDTH-1:0]             ki_gain;
   logic [GAIN_WIDTH-1:0]             kd_gain;
   logic signed [SPEED_WIDTH-1:0]     base_cmd;
   logic signed [ERROR_WIDTH-1:0]     held_error;
   logic signed [INTEGRAL_WIDTH-1:0]  error_integral;

   steer_result_type expected_steering[$];
   int            fail_count = 0;
   int            idle_pct   = 0;      // chance in percent of an idle burst on either side
   int            stall_left = 0;

   always #6 clock = ~clock;

   line_follow_pid_steering #(
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // state after reset: default gains and base speed, no error seen yet
   function automatic void steering_reset();
      kp_gain        = PROP_GAIN_RESET;
      ki_gain        = INTEG_GAIN_RESET;
      kd_gain        = DERIV_GAIN_RESET;
      base_cmd       = BASE_SPEED_RESET;
      held_error     = '0;
      error_integral = '0;
   endfunction

   // register write into the model, indexes past the list change nothing
   function automatic void steering_configure(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                              input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         REG_PROP_GAIN:  kp_gain  = data;
         REG_INTEG_GAIN: ki_gain  = data;
         REG_DERIV_GAIN: kd_gain  = data;
         REG_BASE_SPEED: base_cmd = data[SPEED_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // one pid step: decode the sensors, update integral and held error, form both speeds
   function automatic steer_result_type steering_step(input logic [SENSOR_WIDTH-1:0] sensors);
      logic signed [ERROR_WIDTH-1:0] err;
      longint        err_l, prev_l, integ_l, lim, acc, corr;
      steer_result_type res;
      err = held_error;
      // upper sensors win, highest first; then the lowest of the lower sensors
      if (sensors[5])      err = ERR_POS3;
      else if (sensors[4]) err = ERR_POS2;
      else if (sensors[3]) err = ERR_POS1;
      else if (sensors[0]) err = ERR_NEG3;
      else if (sensors[1]) err = ERR_NEG2;
      else if (sensors[2]) err = ERR_NEG1;
      err_l   = longint'(err);
      prev_l  = longint'(held_error);
      lim     = longint'(1) << (INTEGRAL_WIDTH - 1);
      integ_l = clamp(longint'(error_integral) + err_l, -lim, lim - 1);
      error_integral = integ_l[INTEGRAL_WIDTH-1:0];
      held_error     = err;
      acc  = longint'(kp_gain) * err_l + longint'(ki_gain) * integ_l
           + longint'(kd_gain) * (err_l - prev_l);
      corr = acc / 256;   // signed division truncates toward zero
      res.line_error  = err;
      res.left_speed  = SPEED_WIDTH'(clamp(longint'(base_cmd) + corr, -SPEED_LIMIT,
                                           SPEED_LIMIT));
      res.right_speed = SPEED_WIDTH'(clamp(longint'(base_cmd) - corr, -SPEED_LIMIT,
                                           SPEED_LIMIT));
      return res;
   endfunction

   // sample transaction: hold valid until accepted, then predict; maybe idle afterwards
   task automatic send_sample(input logic [SENSOR_WIDTH-1:0] sensors);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sensors};
      do @(posedge clock); while (!req_tready);
      expected_steering.push_back(steering_step(sensors));
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic stop_samples();
      req_tvalid <= 1'b0;
   endtask

   // every sample gives a result, so an empty store means the block is idle
   task automatic wait_drained();
      while (expected_steering.size() != 0) @(posedge clock);
   endtask

   // register write transaction; valid stays high unless this is the last write
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      steering_configure(idx, data);
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic program_regs(input logic [GAIN_WIDTH-1:0] kp, input logic [GAIN_WIDTH-1:0] ki,
                               input logic [GAIN_WIDTH-1:0] kd,
                               input logic [CSR_DATA_WIDTH-1:0] base_word);
      wait_drained();
      write_csr(REG_PROP_GAIN,  kp, 1'b0);
      write_csr(REG_INTEG_GAIN, ki, 1'b0);
      write_csr(REG_DERIV_GAIN, kd, 1'b0);
      write_csr(REG_BASE_SPEED, base_word, 1'b1);
   endtask

   // random gain, extremes often
   function automatic logic [GAIN_WIDTH-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return GAIN_WIDTH'($urandom_range(0, 1023));
         3:       return GAIN_WIDTH'($urandom_range(0, 8191));
         default: return GAIN_WIDTH'($urandom);
      endcase
   endfunction

   // random base word with junk above the 9 speed bits
   function automatic logic [CSR_DATA_WIDTH-1:0] pick_base();
      logic [SPEED_WIDTH-1:0] b;
      case ($urandom_range(0, 5))
         0:       b = 9'h100;                 // -256
         1:       b = 9'h101;                 // -255
         2:       b = 9'h0ff;                 // 255
         3:       b = '0;
         default: b = SPEED_WIDTH'($urandom);
      endcase
      return {7'($urandom), b};
   endfunction

   // ---------------------------------------------------------------------------------------
   // result side: random stall bursts while idling is on
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result transaction checker: each one against the oldest prediction
   always @(posedge clock) begin : check_results
      steer_result_type got;
      steer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.line_error  = rsp_tdata[2:0];
         got.left_speed  = rsp_tdata[11:3];
         got.right_speed = rsp_tdata[20:12];
         if (expected_steering.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: result with nothing expected: err %0d left %0d right %0d",
                        $realtime, got.line_error, got.left_speed, got.right_speed);
         end else begin
            want = expected_steering.pop_front();
            if (got.line_error !== want.line_error || got.left_speed !== want.left_speed ||
                got.right_speed !== want.right_speed) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: mismatch err %0d/%0d left %0d/%0d right %0d/%0d (exp/act)",
                           $realtime, want.line_error, got.line_error, want.left_speed,
                           got.left_speed, want.right_speed, got.right_speed);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // sensor decode at default gains: held zero right after reset, each sensor alone,
   // priority among mixed patterns, hold after a seen line
   task automatic test_error_decode();
      logic [SENSOR_WIDTH-1:0] pattern[$];
      pattern = '{6'd0, 6'd0, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32, 6'd0, 6'd63,
                  6'd9, 6'd7, 6'd6, 6'd5, 6'd48, 6'd24, 6'd0};
      idle_pct = 0;
      foreach (pattern[k]) send_sample(pattern[k]);
      stop_samples();
   endtask

   // gains and base speed at their extremes, speeds pinned by saturation
   task automatic test_register_extremes();
      program_regs('1, '1, '1, {7'($urandom), 9'h0ff});
      send_sample(6'd32);
      send_sample(6'd1);
      send_sample(6'd0);
      send_sample(6'd4);
      stop_samples();
      // base of -256 still bounded to -255
      program_regs('0, '0, '0, {7'($urandom), 9'h100});
      send_sample(6'd8);
      send_sample(6'd0);
      stop_samples();
      program_regs('0, '0, '0, {7'($urandom), 9'h101});
      send_sample(6'd2);
      stop_samples();
   endtask

   // half gain on a negative error: correction must truncate toward zero, not floor
   task automatic test_truncation_toward_zero();
      program_regs(16'd128, '0, '0, '0);
      send_sample(6'd1);
      send_sample(6'd4);
      send_sample(6'd32);
      stop_samples();
   endtask

   // writes past the register list must leave every setting as it was
   task automatic test_unused_register_index();
      program_regs(16'd256, 16'd3, 16'd512, 16'd7);
      @(posedge clock);
      write_csr(CSR_INDEX_WIDTH'(REG_COUNT), CSR_DATA_WIDTH'($urandom), 1'b0);
      write_csr('1, CSR_DATA_WIDTH'($urandom), 1'b0);
      write_csr(CSR_INDEX_WIDTH'($urandom_range(REG_COUNT, 254)), CSR_DATA_WIDTH'($urandom),
                1'b1);
      send_sample(6'd16);
      send_sample(6'd2);
      send_sample(6'd0);
      stop_samples();
   endtask

   // integral ramped up, down past zero and back; unity integral gain shows it on the speeds
   task automatic test_integral_ramp();
      int pos_items;
      int neg_items;
      pos_items = 60;
      neg_items = 120;
      program_regs('0, 16'd256, '0, '0);
      idle_pct = 10;
      for (int k = 0; k < pos_items; k++) send_sample({1'b1, 5'($urandom)});
      for (int k = 0; k < neg_items; k++) send_sample({3'b000, 2'($urandom), 1'b1});
      // back up, every sample at the top error
      for (int k = 0; k < 30; k++) send_sample({1'b1, 5'($urandom)});
      stop_samples();
      idle_pct = 0;
   endtask

   // random runs of sensor patterns under a random setting of all registers
   task automatic test_random_traffic(input int n_items, input int idle);
      int                      sent;
      int                      run_len;
      int                      kind;
      logic [SENSOR_WIDTH-1:0] single;
      logic [SENSOR_WIDTH-1:0] s;
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_base());
      idle_pct = idle;
      sent = 0;
      while (sent < n_items) begin
         run_len = $urandom_range(1, 24);
         kind    = $urandom_range(0, 5);
         single  = SENSOR_WIDTH'(1) << $urandom_range(0, SENSOR_WIDTH - 1);
         for (int j = 0; j < run_len; j++) begin
            case (kind)
               0: s = '0;                                          // line lost, error held
               1: s = single;                                      // steady position
               2: s = SENSOR_WIDTH'($urandom);
               3: s = {3'($urandom_range(1, 7)), 3'($urandom)};    // upper side
               4: s = {3'b000, 3'($urandom_range(1, 7))};          // lower side only
               default: s = ($urandom_range(0, 1) != 0) ? single : '0;
            endcase
            send_sample(s);
            sent++;
         end
      end
      stop_samples();
   endtask

   // ---------------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      steering_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_error_decode();
      test_register_extremes();
      test_truncation_toward_zero();
      test_unused_register_index();
      test_integral_ramp();
      test_random_traffic(160, 25);
      test_random_traffic(160, 0);
      test_random_traffic(160, 40);
      test_random_traffic(160, 15);
      // closing stretch with both sides always ready
      test_random_traffic(160, 0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_steering.size() == 0) begin
         $display("tb_line_follow_pid_steering: PASS");
      end else begin
         $display("tb_line_follow_pid_steering: FAIL");
      end
      $finish;
   end

   // run limit well above the slowest legal run
   initial begin
      #(20_000_000);
      $display("tb_line_follow_pid_steering: FAIL");
      $finish;
   end

endmodule

[filelist.f]
sv/lfps_pkg.sv
sv/lfps_front.sv
sv/lfps_queue.sv
sv/lfps_back.sv
sv/line_follow_pid_steering.sv
verif/tb_line_follow_pid_steering.sv
